### design/kavf_pkg.sv
// Package for the two-state altitude/velocity Kalman filter.
// Types, codes, saturation helpers and the sequencer's micro-operation table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kavf_pkg;

  localparam logic signed [47:0] COV_INIT = 48'sh0005_DC00_0000; // 1500.0 in Q24.24

  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_PREDICT = 2'd1,
    CMD_UPDATE  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MEAS_VAR  = 2'd0,
    REG_START_POS = 2'd1,
    REG_START_VEL = 2'd2
  } reg_idx_t;

  // saturation width of a scaled product
  typedef enum logic [1:0] {
    SAT_32 = 2'd0,
    SAT_48 = 2'd1,
    SAT_63 = 2'd2,
    SAT_64 = 2'd3
  } satw_t;

  typedef enum logic [3:0] {
    OP_D, OP_2D, OP_D2, OP_D3, OP_D4, OP_VEL, OP_PZV, OP_PVV,
    OP_PZZ, OP_A, OP_Y, OP_KZ, OP_KV
  } opnd_t;

  typedef enum logic [2:0] {
    DST_D2, DST_D3, DST_D4, DST_KZ, DST_KV, DST_ACC
  } dst_t;

  typedef enum logic [2:0] {
    R_POS, R_VEL, R_PZZ, R_PZV, R_PVV
  } rsel_t;

  typedef struct packed {
    logic        is_div;
    opnd_t       op_a;
    opnd_t       op_b;
    logic [5:0]  sh;
    satw_t       satw;
    dst_t        dst;
    logic        acc_load;
    logic        acc_sub;
    logic        wb;
    rsel_t       rsel;
    logic        last;
  } uop_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [5:0]         sh;
    satw_t              satw;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [47:0] num;
    logic [47:0]        den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] q;
  } div_rsp_t;

  function automatic uop_t mk(input logic is_div, input opnd_t a, input opnd_t b,
                              input logic [5:0] sh, input satw_t satw, input dst_t dst,
                              input logic ld, input logic sub, input logic wb,
                              input rsel_t rsel, input logic last);
    uop_t u;
    u.is_div   = is_div;
    u.op_a     = a;
    u.op_b     = b;
    u.sh       = sh;
    u.satw     = satw;
    u.dst      = dst;
    u.acc_load = ld;
    u.acc_sub  = sub;
    u.wb       = wb;
    u.rsel     = rsel;
    u.last     = last;
    return u;
  endfunction

  // Micro-program: predict (upd = 0) and measurement update (upd = 1)
  function automatic uop_t uop_lookup(input logic upd, input logic [3:0] step);
    uop_t u;
    u = mk(1'b0, OP_D, OP_D, 6'd0, SAT_64, DST_D2, 1'b0, 1'b0, 1'b0, R_POS, 1'b1);
    if (!upd) begin
      unique case (step)
        4'd0: u = mk(1'b0, OP_D,   OP_D,  6'd0,  SAT_64, DST_D2,  1'b0, 1'b0, 1'b0, R_POS, 1'b0);
        4'd1: u = mk(1'b0, OP_D2,  OP_D,  6'd0,  SAT_64, DST_D3,  1'b0, 1'b0, 1'b0, R_POS, 1'b0);
        4'd2: u = mk(1'b0, OP_D2,  OP_D2, 6'd32, SAT_63, DST_D4,  1'b0, 1'b0, 1'b0, R_POS, 1'b0);
        4'd3: u = mk(1'b0, OP_VEL, OP_D,  6'd16, SAT_32, DST_ACC, 1'b1, 1'b0, 1'b1, R_POS, 1'b0);
        4'd4: u = mk(1'b0, OP_PZV, OP_2D, 6'd16, SAT_48, DST_ACC, 1'b1, 1'b0, 1'b0, R_PZZ, 1'b0);
        4'd5: u = mk(1'b0, OP_PVV, OP_D2, 6'd32, SAT_48, DST_ACC, 1'b0, 1'b0, 1'b0, R_PZZ, 1'b0);
        4'd6: u = mk(1'b0, OP_A,   OP_D4, 6'd26, SAT_48, DST_ACC, 1'b0, 1'b0, 1'b1, R_PZZ, 1'b0);
        4'd7: u = mk(1'b0, OP_PVV, OP_D,  6'd16, SAT_48, DST_ACC, 1'b1, 1'b0, 1'b0, R_PZV, 1'b0);
        4'd8: u = mk(1'b0, OP_A,   OP_D3, 6'd41, SAT_48, DST_ACC, 1'b0, 1'b0, 1'b1, R_PZV, 1'b0);
        4'd9: u = mk(1'b0, OP_A,   OP_D2, 6'd24, SAT_48, DST_ACC, 1'b1, 1'b0, 1'b1, R_PVV, 1'b1);
        default: ;
      endcase
    end else begin
      unique case (step)
        4'd0: u = mk(1'b1, OP_PZZ, OP_D,  6'd0,  SAT_64, DST_KZ,  1'b0, 1'b0, 1'b0, R_POS, 1'b0);
        4'd1: u = mk(1'b1, OP_PZV, OP_D,  6'd0,  SAT_64, DST_KV,  1'b0, 1'b0, 1'b0, R_POS, 1'b0);
        4'd2: u = mk(1'b0, OP_KZ,  OP_Y,  6'd30, SAT_32, DST_ACC, 1'b1, 1'b0, 1'b1, R_POS, 1'b0);
        4'd3: u = mk(1'b0, OP_KV,  OP_Y,  6'd30, SAT_32, DST_ACC, 1'b1, 1'b0, 1'b1, R_VEL, 1'b0);
        4'd4: u = mk(1'b0, OP_PZV, OP_KV, 6'd30, SAT_48, DST_ACC, 1'b1, 1'b1, 1'b1, R_PVV, 1'b0);
        4'd5: u = mk(1'b0, OP_PZV, OP_KZ, 6'd30, SAT_48, DST_ACC, 1'b1, 1'b1, 1'b1, R_PZV, 1'b0);
        4'd6: u = mk(1'b0, OP_PZZ, OP_KZ, 6'd30, SAT_48, DST_ACC, 1'b1, 1'b1, 1'b1, R_PZZ, 1'b1);
        default: ;
      endcase
    end
    return u;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    if (x > 52'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -52'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [51:0] x);
    if (x > 52'sd140737488355327) return 48'sh7FFF_FFFF_FFFF;
    if (x < -52'sd140737488355328) return 48'sh8000_0000_0000;
    return x[47:0];
  endfunction

endpackage

`default_nettype wire

### design/kavf_in_if.sv
// Input channel of the altitude/velocity filter: valid/ready and one command item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface kavf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [19:0]        delta_time;
  logic [31:0]        accel_variance;
  logic signed [31:0] measured_position;

  modport source (output valid, cmd, delta_time, accel_variance, measured_position,
                  input ready);
  modport sink   (input valid, cmd, delta_time, accel_variance, measured_position,
                  output ready);
endinterface

`default_nettype wire

### design/kavf_out_if.sv
// Output channel of the altitude/velocity filter: valid/ready and the estimate.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface kavf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;

  modport source (output valid, position, velocity, input ready);
  modport sink   (input valid, position, velocity, output ready);
endinterface

`default_nettype wire

### design/kalman_altitude_velocity_filter.sv
// Top level of the two-state altitude/velocity Kalman filter: sequencer, state,
// registers and output stage. Uses kavf_pkg, kavf_in_if, kavf_out_if, kavf_mul, kavf_div.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Payload                                            Handshake
// in_ch      in   cmd, delta_time, accel_variance, measured_position valid/ready
// out_ch     out  position, velocity                                 valid/ready
// wr_*       in   wr_index (register), wr_data                       wr_en, no wait
//
// Steps: init and the unused command go straight to the output stage; predict runs ten
// products through the shared multiplier; update runs two serial divisions for the
// gains, then five products.
// Reset: synchronous, active high; estimate 0, covariance diagonal 1500, registers to
// their defaults. in_ch.ready is high only while the sequencer is idle; a finished
// item waits in the output register, and the next item is taken meanwhile.

module kalman_altitude_velocity_filter (
  input  logic              clk,
  input  logic              rst,
  kavf_in_if.sink           in_ch,
  kavf_out_if.source        out_ch,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [31:0]       wr_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // Configuration
  logic [31:0]         meas_var;
  logic signed [31:0]  start_pos;
  logic signed [31:0]  start_vel;

  // Filter state
  logic signed [31:0]  pos;
  logic signed [31:0]  vel;
  logic signed [47:0]  pzz;
  logic signed [47:0]  pzv;
  logic signed [47:0]  pvv;

  // Sequencer and working registers
  state_t              state;
  logic [3:0]          step;
  logic                upd;
  logic [19:0]         dt;
  logic [31:0]         accv;
  logic signed [32:0]  y;
  logic [47:0]         s;
  logic                s_pos;
  logic [39:0]         d2;
  logic [59:0]         d3;
  logic [47:0]         d4;
  logic signed [31:0]  kz;
  logic signed [31:0]  kv;
  logic signed [51:0]  acc;

  // Output stage
  logic                out_valid;
  logic signed [31:0]  out_pos;
  logic signed [31:0]  out_vel;

  kavf_pkg::uop_t      uop;
  kavf_pkg::mul_req_t  mreq;
  kavf_pkg::mul_rsp_t  mrsp;
  kavf_pkg::div_req_t  dreq;
  kavf_pkg::div_rsp_t  drsp;

  logic signed [51:0]  base;
  logic signed [51:0]  term;
  logic signed [51:0]  acc_next;
  logic signed [49:0]  s_full;
  logic                in_take;
  logic                out_free;
  logic                adv;

  function automatic logic signed [63:0] opnd(input kavf_pkg::opnd_t sel);
    unique case (sel)
      kavf_pkg::OP_D:   return {44'd0, dt};
      kavf_pkg::OP_2D:  return {43'd0, dt, 1'b0};
      kavf_pkg::OP_D2:  return {24'd0, d2};
      kavf_pkg::OP_D3:  return {4'd0, d3};
      kavf_pkg::OP_D4:  return {16'd0, d4};
      kavf_pkg::OP_VEL: return 64'(vel);
      kavf_pkg::OP_PZV: return 64'(pzv);
      kavf_pkg::OP_PVV: return 64'(pvv);
      kavf_pkg::OP_PZZ: return 64'(pzz);
      kavf_pkg::OP_A:   return {32'd0, accv};
      kavf_pkg::OP_Y:   return 64'(y);
      kavf_pkg::OP_KZ:  return 64'(kz);
      kavf_pkg::OP_KV:  return 64'(kv);
      default:          return 64'sd0;
    endcase
  endfunction

  assign uop      = kavf_pkg::uop_lookup(upd, step);
  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  // Innovation variance S = Pzz + R, R moved up to Q24.24
  assign s_full = 50'(pzz) + $signed({10'd0, meas_var, 8'd0});

  always_comb begin
    mreq.start = (state == ST_ISSUE) && !uop.is_div;
    mreq.a     = opnd(uop.op_a);
    mreq.b     = opnd(uop.op_b);
    mreq.sh    = uop.sh;
    mreq.satw  = uop.satw;
    dreq.start = (state == ST_ISSUE) && uop.is_div && s_pos;
    dreq.num   = (uop.op_a == kavf_pkg::OP_PZZ) ? pzz : pzv;
    dreq.den   = s;
  end

  // Accumulate: start from the target register or keep summing
  always_comb begin
    unique case (uop.rsel)
      kavf_pkg::R_POS: base = 52'(pos);
      kavf_pkg::R_VEL: base = 52'(vel);
      kavf_pkg::R_PZZ: base = 52'(pzz);
      kavf_pkg::R_PZV: base = 52'(pzv);
      kavf_pkg::R_PVV: base = 52'(pvv);
      default:         base = 52'sd0;
    endcase
    if (!uop.acc_load) base = acc;
    term     = mrsp.res[51:0];
    acc_next = uop.acc_sub ? (base - term) : (base + term);
  end

  // Step finished: skipped gain, product or quotient in
  assign adv = ((state == ST_ISSUE) && uop.is_div && !s_pos) ||
               ((state == ST_MUL) && mrsp.done) ||
               ((state == ST_DIV) && drsp.done);

  kavf_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  kavf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      meas_var  <= 32'd65536;
      start_pos <= '0;
      start_vel <= '0;
    end else if (wr_en) begin
      unique case (kavf_pkg::reg_idx_t'(wr_index))
        kavf_pkg::REG_MEAS_VAR:  meas_var  <= wr_data;
        kavf_pkg::REG_START_POS: start_pos <= wr_data;
        kavf_pkg::REG_START_VEL: start_vel <= wr_data;
        default: ;
      endcase
    end
  end

  // Sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      upd   <= 1'b0;
      pos   <= '0;
      vel   <= '0;
      pzz   <= kavf_pkg::COV_INIT;
      pzv   <= '0;
      pvv   <= kavf_pkg::COV_INIT;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            dt   <= in_ch.delta_time;
            accv <= in_ch.accel_variance;
            y    <= 33'(in_ch.measured_position) - 33'(pos);
            s    <= s_full[47:0];
            s_pos <= !s_full[49] && (s_full != 50'sd0);
            step <= '0;
            unique case (kavf_pkg::cmd_t'(in_ch.cmd))
              kavf_pkg::CMD_INIT: begin
                pos   <= start_pos;
                vel   <= start_vel;
                pzz   <= kavf_pkg::COV_INIT;
                pzv   <= '0;
                pvv   <= kavf_pkg::COV_INIT;
                state <= ST_DONE;
              end
              kavf_pkg::CMD_PREDICT: begin
                upd   <= 1'b0;
                state <= ST_ISSUE;
              end
              kavf_pkg::CMD_UPDATE: begin
                upd   <= 1'b1;
                state <= ST_ISSUE;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_ISSUE: begin
          if (uop.is_div) begin
            state <= ST_DIV;
            // non-positive S: both gains zero, no division
            if (!s_pos) begin
              if (uop.dst == kavf_pkg::DST_KZ) kz <= '0;
              else kv <= '0;
            end
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mrsp.done) begin
            unique case (uop.dst)
              kavf_pkg::DST_D2: d2 <= mrsp.res[39:0];
              kavf_pkg::DST_D3: d3 <= mrsp.res[59:0];
              kavf_pkg::DST_D4: d4 <= mrsp.res[47:0];
              kavf_pkg::DST_ACC: begin
                acc <= acc_next;
                if (uop.wb) begin
                  unique case (uop.rsel)
                    kavf_pkg::R_POS: pos <= kavf_pkg::sat32(acc_next);
                    kavf_pkg::R_VEL: vel <= kavf_pkg::sat32(acc_next);
                    kavf_pkg::R_PZZ: pzz <= kavf_pkg::sat48(acc_next);
                    kavf_pkg::R_PZV: pzv <= kavf_pkg::sat48(acc_next);
                    kavf_pkg::R_PVV: pvv <= kavf_pkg::sat48(acc_next);
                    default: ;
                  endcase
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (drsp.done) begin
            if (uop.dst == kavf_pkg::DST_KZ) kz <= drsp.q;
            else kv <= drsp.q;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase

      // advance the micro-program once a step has finished
      if (adv) begin
        if (uop.last) begin
          state <= ST_DONE;
        end else begin
          step  <= step + 4'd1;
          state <= ST_ISSUE;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
        out_pos   <= pos;
        out_vel   <= vel;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ch.ready     = (state == ST_IDLE);
  assign out_ch.valid    = out_valid;
  assign out_ch.position = out_pos;
  assign out_ch.velocity = out_vel;

  // Products and quotients arrive only while the sequencer waits for them
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> state == ST_MUL)
    else $error("product returned outside a multiply step");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == ST_DIV)
    else $error("quotient returned outside a divide step");

  // Init loads the start position
  a_init: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_ch.cmd == kavf_pkg::CMD_INIT) |=> pos == $past(start_pos))
    else $error("init did not load the start position");

  // A finished item always reaches the output register
  a_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> out_ch.valid)
    else $error("finished item not presented");

endmodule

`default_nettype wire

### design/kavf_mul.sv
// Shared multiply-scale-saturate unit: 64x64 signed product in four 64x16 passes,
// then round half away from zero, shift and saturate. Uses kavf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kavf_mul (
  input  logic               clk,
  input  logic               rst,
  input  kavf_pkg::mul_req_t req,
  output kavf_pkg::mul_rsp_t rsp
);

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_ACC  = 5'b00010,
    M_RND  = 5'b00100,
    M_SHF  = 5'b01000,
    M_SAT  = 5'b10000
  } mst_t;

  mst_t                st;
  logic                neg;
  logic [63:0]         ua;
  logic [63:0]         ub;
  logic [127:0]        prod;
  logic [1:0]          cnt;
  logic [5:0]          sh;
  kavf_pkg::satw_t     satw;
  logic                done;
  logic signed [63:0]  res;

  logic [79:0]         pp;
  logic [127:0]        rnd;
  logic [63:0]         lim;
  logic [63:0]         mag;

  always_comb begin
    pp  = ua * ub[63:48];
    rnd = (sh == 6'd0) ? 128'd0 : (128'd1 << (sh - 6'd1));
    unique case (satw)
      kavf_pkg::SAT_32: lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
      kavf_pkg::SAT_48: lim = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
      kavf_pkg::SAT_63: lim = neg ? 64'h4000_0000_0000_0000 : 64'h3FFF_FFFF_FFFF_FFFF;
      default:          lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    endcase
    mag = (prod > {64'd0, lim}) ? lim : prod[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= M_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        M_IDLE: begin
          if (req.start) begin
            neg  <= req.a[63] ^ req.b[63];
            ua   <= req.a[63] ? (~req.a + 64'd1) : req.a;
            ub   <= req.b[63] ? (~req.b + 64'd1) : req.b;
            sh   <= req.sh;
            satw <= req.satw;
            prod <= '0;
            cnt  <= 2'd0;
            st   <= M_ACC;
          end
        end
        M_ACC: begin
          prod <= {prod[111:0], 16'd0} + {48'd0, pp};
          ub   <= {ub[47:0], 16'd0};
          cnt  <= cnt + 2'd1;
          if (cnt == 2'd3) st <= M_RND;
        end
        M_RND: begin
          prod <= prod + rnd;
          st   <= M_SHF;
        end
        M_SHF: begin
          prod <= prod >> sh;
          st   <= M_SAT;
        end
        M_SAT: begin
          res  <= neg ? (~mag + 64'd1) : mag;
          done <= 1'b1;
          st   <= M_IDLE;
        end
        default: st <= M_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

`default_nettype wire

### design/kavf_div.sv
// Bit-serial gain divider: signed numerator over positive denominator, Q1.30
// quotient with truncated magnitude, one bit per cycle. Uses kavf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kavf_div (
  input  logic               clk,
  input  logic               rst,
  input  kavf_pkg::div_req_t req,
  output kavf_pkg::div_rsp_t rsp
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_INIT = 3'b010,
    D_RUN  = 3'b100
  } dst_t;

  dst_t        st;
  logic        neg;
  logic [47:0] n;
  logic [47:0] d;
  logic [47:0] r;
  logic [31:0] q;
  logic [4:0]  cnt;
  logic        done;
  logic [48:0] r2;

  assign r2 = {r, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= D_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        D_IDLE: begin
          if (req.start) begin
            neg <= req.num[47];
            n   <= req.num[47] ? (~req.num + 48'd1) : req.num;
            d   <= req.den;
            st  <= D_INIT;
          end
        end
        D_INIT: begin
          cnt <= 5'd0;
          if ({1'b0, n} >= {d, 1'b0}) begin
            q    <= 32'h7FFF_FFFF;
            done <= 1'b1;
            st   <= D_IDLE;
          end else if (n >= d) begin
            q  <= 32'd1;
            r  <= n - d;
            st <= D_RUN;
          end else begin
            q  <= 32'd0;
            r  <= n;
            st <= D_RUN;
          end
        end
        D_RUN: begin
          if (r2 >= {1'b0, d}) begin
            r <= 48'(r2 - {1'b0, d});
            q <= {q[30:0], 1'b1};
          end else begin
            r <= r2[47:0];
            q <= {q[30:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd29) begin
            done <= 1'b1;
            st   <= D_IDLE;
          end
        end
        default: st <= D_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.q    = neg ? (~q + 32'd1) : q;

endmodule

`default_nettype wire

### tb/sv/tb_kalman_altitude_velocity_filter.sv
// Testbench for the two-state altitude/velocity Kalman filter: a directed table, then random
// phases, checked item by item against a fixed-point predictor of the filter.
// Depends on kavf_pkg, kavf_in_if, kavf_out_if and kalman_altitude_velocity_filter.
`timescale 1ns / 1ps

module tb_kalman_altitude_velocity_filter;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 175;
  localparam int HOLD_AT      = 200;  // result count at which the sink holds off
  localparam int HOLD_CYCLES  = 600;

  // One row of the stimulus plan: either a register write or an input item.
  typedef struct {
    bit                 is_cfg;
    kavf_pkg::reg_idx_t idx;
    logic [31:0]        data;
    kavf_pkg::cmd_t     cmd;
    logic [19:0]        dt;
    logic [31:0]        av;
    logic signed [31:0] meas;
    bit                 typed;   // expected estimate given in the row itself
    logic signed [31:0] exp_pos;
    logic signed [31:0] exp_vel;
  } plan_row_t;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } estimate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        wr_en    = 1'b0;
  logic [1:0]  wr_index = '0;
  logic [31:0] wr_data  = '0;

  kavf_in_if  in_ch ();
  kavf_out_if out_ch ();

  kalman_altitude_velocity_filter dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #5 clk = ~clk;

  // Filter model: registers and state at the block's widths.
  logic [31:0]        mv_reg;
  logic signed [31:0] sp_reg, sv_reg;
  logic signed [31:0] f_pos, f_vel;
  logic signed [47:0] f_pzz, f_pzv, f_pvv;

  estimate_t   estimates [$];
  plan_row_t   plan [$];
  int          errors = 0;
  int          results = 0;
  int          cycles = 0;
  int          send_quiet = 0;   // percentage of items forced to go without any gap
  int          sink_quiet = 0;   // percentage of sink stall draws forced to zero

  // ---------------------------------------------------------------------------
  // Arithmetic of the filter
  // ---------------------------------------------------------------------------
  function automatic longint clip(longint x, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic logic [127:0] magnitude(longint x);
    logic [127:0] m;
    m = (x < 0) ? 128'(-x) : 128'(x);
    return m;
  endfunction

  // round(a*b / 2^sh) half away from zero, saturated to a signed width
  function automatic longint scaled_product(longint a, longint b, int sh, int bits);
    bit           neg;
    logic [127:0] p, lim;
    neg = (a < 0) != (b < 0);
    p = magnitude(a) * magnitude(b);
    p = (p + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? (128'd1 << (bits - 1)) : (128'd1 << (bits - 1)) - 1;
    if (p > lim) p = lim;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // num/den in signed Q1.30, magnitude truncated, held below 2^31
  function automatic longint gain_q30(longint num, longint den);
    logic [127:0] q;
    q = (magnitude(num) << 30) / 128'(den);
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic void reset_filter();
    mv_reg = 32'h0001_0000;
    sp_reg = '0;
    sv_reg = '0;
    f_pos = '0;
    f_vel = '0;
    f_pzz = kavf_pkg::COV_INIT;
    f_pzv = '0;
    f_pvv = kavf_pkg::COV_INIT;
  endfunction

  // Advance the model by one item and return the estimate it leaves.
  function automatic estimate_t filter_step(kavf_pkg::cmd_t cmd, logic [19:0] dt,
                                            logic [31:0] av, logic signed [31:0] meas);
    longint d, d2, d3, d4, a, pzz, pzv, pvv, y, s, kz, kv;
    estimate_t e;
    d = longint'(dt);
    a = longint'(av);
    pzz = longint'(f_pzz);
    pzv = longint'(f_pzv);
    pvv = longint'(f_pvv);
    case (cmd)
      kavf_pkg::CMD_INIT: begin
        f_pos = sp_reg;
        f_vel = sv_reg;
        f_pzz = kavf_pkg::COV_INIT;
        f_pzv = '0;
        f_pvv = kavf_pkg::COV_INIT;
      end
      kavf_pkg::CMD_PREDICT: begin
        d2 = d * d;
        d3 = d2 * d;
        d4 = scaled_product(d2, d2, 32, 63);
        f_pos = 32'(clip(longint'(f_pos) + scaled_product(longint'(f_vel), d, 16, 32), 32));
        f_pzz = 48'(clip(pzz + scaled_product(pzv, 2 * d, 16, 48)
                         + scaled_product(pvv, d2, 32, 48)
                         + scaled_product(a, d4, 26, 48), 48));
        f_pzv = 48'(clip(pzv + scaled_product(pvv, d, 16, 48)
                         + scaled_product(a, d3, 41, 48), 48));
        f_pvv = 48'(clip(pvv + scaled_product(a, d2, 24, 48), 48));
      end
      kavf_pkg::CMD_UPDATE: begin
        y = longint'(meas) - longint'(f_pos);
        s = pzz + (longint'(mv_reg) <<< 8);
        kz = 0;
        kv = 0;
        // a non-positive innovation variance leaves both gains at zero
        if (s > 0) begin
          kz = gain_q30(pzz, s);
          kv = gain_q30(pzv, s);
        end
        f_pos = 32'(clip(longint'(f_pos) + scaled_product(kz, y, 30, 32), 32));
        f_vel = 32'(clip(longint'(f_vel) + scaled_product(kv, y, 30, 32), 32));
        f_pvv = 48'(clip(pvv - scaled_product(pzv, kv, 30, 48), 48));
        f_pzv = 48'(clip(pzv - scaled_product(pzv, kz, 30, 48), 48));
        f_pzz = 48'(clip(pzz - scaled_product(pzz, kz, 30, 48), 48));
      end
      default: ;  // unused command: hold everything
    endcase
    e.pos = f_pos;
    e.vel = f_vel;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Plan building
  // ---------------------------------------------------------------------------
  function automatic plan_row_t blank_row();
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.idx     = kavf_pkg::REG_MEAS_VAR;
    r.data    = '0;
    r.cmd     = kavf_pkg::CMD_NONE;
    r.dt      = '0;
    r.av      = '0;
    r.meas    = '0;
    r.typed   = 1'b0;
    r.exp_pos = '0;
    r.exp_vel = '0;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(kavf_pkg::reg_idx_t idx, logic [31:0] data);
    plan_row_t r;
    r = blank_row();
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t item_row(kavf_pkg::cmd_t cmd, logic [19:0] dt, logic [31:0] av,
                                         logic [31:0] meas);
    plan_row_t r;
    r = blank_row();
    r.cmd = cmd;
    r.dt = dt;
    r.av = av;
    r.meas = meas;
    return r;
  endfunction

  function automatic plan_row_t typed_row(kavf_pkg::cmd_t cmd, logic [19:0] dt, logic [31:0] p,
                                          logic [31:0] v);
    plan_row_t r;
    r = item_row(cmd, dt, 32'h0, 32'h0);
    r.typed = 1'b1;
    r.exp_pos = p;
    r.exp_vel = v;
    return r;
  endfunction

  // Gap before an item or a stall length: mostly short, now and then long.
  function automatic int pick_gap(int quiet_pct);
    int r;
    if ($urandom_range(0, 99) < quiet_pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Wait until every expected estimate has come back, then let the block settle.
  task automatic drain();
    while (estimates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(kavf_pkg::reg_idx_t idx, logic [31:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en    <= 1'b0;
    case (idx)
      kavf_pkg::REG_MEAS_VAR:  mv_reg = data;
      kavf_pkg::REG_START_POS: sp_reg = data;
      kavf_pkg::REG_START_VEL: sv_reg = data;
      default: ;
    endcase
  endtask

  task automatic send_item(plan_row_t r);
    int gap;
    estimate_t e;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.cmd               <= r.cmd;
    in_ch.delta_time        <= r.dt;
    in_ch.accel_variance    <= r.av;
    in_ch.measured_position <= r.meas;
    // hold the item until the block takes it
    do @(posedge clk); while (!in_ch.ready);
    e = filter_step(r.cmd, r.dt, r.av, r.meas);
    if (r.typed) begin
      e.pos = r.exp_pos;
      e.vel = r.exp_vel;
    end
    estimates.push_back(e);
  endtask

  task automatic run_row(plan_row_t r);
    if (r.is_cfg) begin
      in_ch.valid <= 1'b0;
      drain();
      write_reg(r.idx, r.data);
    end else begin
      send_item(r);
    end
  endtask

  // Random item: mostly predict/update with sensible steps and measurements near
  // the current estimate; now and then full-range fields and the other commands.
  function automatic plan_row_t random_row();
    plan_row_t r;
    int k;
    k = $urandom_range(0, 99);
    r = item_row(kavf_pkg::CMD_PREDICT, '0, '0, '0);
    if (k < 4) r.cmd = kavf_pkg::CMD_INIT;
    else if (k < 8) r.cmd = kavf_pkg::CMD_NONE;
    else if (k < 52) r.cmd = kavf_pkg::CMD_PREDICT;
    else r.cmd = kavf_pkg::CMD_UPDATE;
    r.dt = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 32'h2_0000));
    r.av = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000);
    if ($urandom_range(0, 9) < 2) r.meas = $urandom;
    else r.meas = f_pos + $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sink: random stalls, one long hold-off, and the checker
  // ---------------------------------------------------------------------------
  int  stall_left = 0;
  bit  held = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!held && results >= HOLD_AT) begin
      // long hold-off so the output register fills and the input stalls
      held <= 1'b1;
      stall_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left <= pick_gap(sink_quiet);
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    estimate_t want;
    int bad;
    bad = 0;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results <= results + 1;
      if (estimates.size() == 0) begin
        bad = 1;
        $display("%0t: unexpected estimate pos=%h vel=%h", $time,
                 out_ch.position, out_ch.velocity);
      end else begin
        want = estimates.pop_front();
        if (out_ch.position !== want.pos) begin
          bad = bad + 1;
          $display("%0t: position expected %h actual %h", $time, want.pos, out_ch.position);
        end
        if (out_ch.velocity !== want.vel) begin
          bad = bad + 1;
          $display("%0t: velocity expected %h actual %h", $time, want.vel, out_ch.velocity);
        end
      end
      if (bad != 0) errors <= errors + bad;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid             <= 1'b0;
    in_ch.cmd               <= kavf_pkg::CMD_NONE;
    in_ch.delta_time        <= '0;
    in_ch.accel_variance    <= '0;
    in_ch.measured_position <= '0;
    reset_filter();

    // Directed table: defaults after reset, extremes, saturation, zero gain.
    plan.push_back(typed_row(kavf_pkg::CMD_NONE, '0, 32'h0, 32'h0));
    plan.push_back(typed_row(kavf_pkg::CMD_INIT, '0, 32'h0, 32'h0));
    plan.push_back(typed_row(kavf_pkg::CMD_PREDICT, '0, 32'h0, 32'h0));
    plan.push_back(item_row(kavf_pkg::CMD_UPDATE, '0, '0, 32'h7FFF_FFFF));
    plan.push_back(item_row(kavf_pkg::CMD_PREDICT, 20'hF_FFFF, 32'hFFFF_FFFF, '0));
    plan.push_back(item_row(kavf_pkg::CMD_UPDATE, 20'hF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000));
    plan.push_back(item_row(kavf_pkg::CMD_PREDICT, 20'h1, 32'h1, 32'h5555_AAAA));
    plan.push_back(item_row(kavf_pkg::CMD_NONE, 20'hA_5A5A, 32'hAAAA_5555, 32'h1234_5678));
    plan.push_back(cfg_row(kavf_pkg::REG_START_POS, 32'h7FFF_FFFF));
    plan.push_back(cfg_row(kavf_pkg::REG_START_VEL, 32'h8000_0000));
    plan.push_back(cfg_row(kavf_pkg::REG_MEAS_VAR, 32'h0));
    plan.push_back(typed_row(kavf_pkg::CMD_INIT, '0, 32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(item_row(kavf_pkg::CMD_PREDICT, 20'h1_0000, '0, '0));
    // zero measurement variance drives the position covariance to zero ...
    plan.push_back(item_row(kavf_pkg::CMD_UPDATE, '0, '0, 32'h0));
    // ... after which the innovation variance is not positive and nothing moves
    plan.push_back(item_row(kavf_pkg::CMD_UPDATE, '0, '0, 32'h7FFF_FFFF));
    plan.push_back(cfg_row(kavf_pkg::REG_MEAS_VAR, 32'hFFFF_FFFF));
    plan.push_back(typed_row(kavf_pkg::CMD_INIT, '0, 32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(item_row(kavf_pkg::CMD_PREDICT, 20'hF_FFFF, 32'hFFFF_FFFF, '0));
    plan.push_back(item_row(kavf_pkg::CMD_PREDICT, 20'hF_FFFF, 32'hFFFF_FFFF, '0));
    plan.push_back(item_row(kavf_pkg::CMD_UPDATE, '0, '0, 32'h8000_0000));
    plan.push_back(cfg_row(kavf_pkg::REG_START_VEL, 32'h7FFF_FFFF));
    plan.push_back(typed_row(kavf_pkg::CMD_INIT, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    plan.push_back(item_row(kavf_pkg::CMD_PREDICT, 20'hF_FFFF, '0, '0));
    plan.push_back(item_row(kavf_pkg::CMD_UPDATE, '0, '0, 32'h8000_0000));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_quiet = 100;
    sink_quiet = 100;
    foreach (plan[i]) run_row(plan[i]);

    // Random phases, each under its own register setting and idling mix.
    for (int p = 0; p < PHASES; p++) begin
      in_ch.valid <= 1'b0;
      drain();
      case (p)
        0: begin
          write_reg(kavf_pkg::REG_MEAS_VAR, 32'hFFFF_FFFF);
          write_reg(kavf_pkg::REG_START_POS, 32'h7FFF_0000);
          write_reg(kavf_pkg::REG_START_VEL, 32'h8000_0000);
        end
        1: begin
          write_reg(kavf_pkg::REG_MEAS_VAR, 32'h0);
          write_reg(kavf_pkg::REG_START_POS, 32'h8000_0000);
          write_reg(kavf_pkg::REG_START_VEL, 32'h7FFF_FFFF);
        end
        default: begin
          write_reg(kavf_pkg::REG_MEAS_VAR,
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000));
          write_reg(kavf_pkg::REG_START_POS, $urandom);
          write_reg(kavf_pkg::REG_START_VEL,
                    ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000));
        end
      endcase
      send_quiet = (p % 3 == 0) ? 100 : 20;
      sink_quiet = (p % 4 == 1) ? 100 : 30;
      send_item(item_row(kavf_pkg::CMD_INIT, '0, '0, '0));
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_row());
    end

    in_ch.valid <= 1'b0;
    while (estimates.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
